// ===== rtl/pol_pkg.sv =====
// Shared types, codes and constants for the positional ordered list.
package pol_pkg;

    localparam int DATA_W       = 32;
    localparam int POS_W        = 10;
    localparam int OP_W         = 3;
    localparam int STATUS_W     = 2;
    localparam int DEF_CAPACITY = 64;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
    localparam logic [OP_W-1:0] OP_GET    = 3'd2;
    localparam logic [OP_W-1:0] OP_LOCATE = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic              eval;   // latch the compare flag
        logic              ins;    // open a gap at idx and write value
        logic              del;    // close the gap at idx
        logic [POS_W-1:0]  idx;    // 0-based cell index of the operation
        logic [POS_W-1:0]  count;  // current list length
        logic [DATA_W-1:0] value;  // value to insert or search for
    } t_cell_cmd;

endpackage

// ===== rtl/pol_cell.sv =====
// One storage cell of the list chain: holds one entry and shifts to its neighbours.
module pol_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                      i_clk,
    input  pol_pkg::t_cell_cmd        i_cmd,
    input  logic [pol_pkg::DATA_W-1:0] i_left,
    input  logic [pol_pkg::DATA_W-1:0] i_right,
    output logic [pol_pkg::DATA_W-1:0] o_value,
    output logic                      o_match,
    output logic [pol_pkg::DATA_W-1:0] o_sel
);
    import pol_pkg::*;

    localparam logic [POS_W-1:0] MY_IDX = POS_W'(CELL_IDX);

    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] n_value;
    logic              r_match;
    logic              n_match;

    always_comb begin
        n_value = r_value;
        if (i_cmd.ins) begin
            if (MY_IDX == i_cmd.idx) begin
                n_value = i_cmd.value;
            end else if (MY_IDX > i_cmd.idx) begin
                n_value = i_left;
            end
        end else if (i_cmd.del) begin
            if (MY_IDX >= i_cmd.idx) begin
                n_value = i_right;
            end
        end
    end

    // Hold the flag unless a compare is requested; only live entries match.
    assign n_match = i_cmd.eval ? ((r_value == i_cmd.value) && (MY_IDX < i_cmd.count))
                                : r_match;

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_match <= n_match;
    end

    assign o_value = r_value;
    assign o_match = r_match;
    assign o_sel   = (MY_IDX == i_cmd.idx) ? r_value : '0;

endmodule

// ===== rtl/pol_reduce.sv =====
// Collapses the chain outputs: first-match position and addressed entry.
module pol_reduce #(
    parameter int CAPACITY = pol_pkg::DEF_CAPACITY
) (
    input  logic [CAPACITY-1:0]                     i_match,
    input  logic [CAPACITY-1:0][pol_pkg::DATA_W-1:0] i_sel,
    output logic [pol_pkg::POS_W-1:0]               o_found,
    output logic [pol_pkg::DATA_W-1:0]              o_data
);
    import pol_pkg::*;

    logic [CAPACITY-1:0] first;

    // Isolate the lowest set match bit.
    assign first = i_match & (~i_match + CAPACITY'(1));

    always_comb begin
        o_found = '0;
        o_data  = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (first[i]) begin
                o_found = o_found | POS_W'(i + 1);
            end
            o_data = o_data | i_sel[i];
        end
    end

endmodule

// ===== rtl/positional_ordered_list.sv =====
// Top level of the positional ordered list: control, chain of cells and result register.
//
// Usage
//   Input channel (i_in_valid / o_in_ready) carries one request: i_op, i_position,
//   i_value. Output channel (o_out_valid / i_out_ready) returns one result per
//   request: o_status, o_data_out, o_found_position, o_list_length, o_is_empty.
//   Entries live in a row of CAPACITY cells; insert and delete shift every cell
//   behind the addressed one by one place, all cells in parallel.
// Steps
//   The state register holds a request in IDLE, EVAL and COMMIT in turn. The
//   accepting edge in IDLE latches it; in EVAL every cell's match flag is
//   registered; in COMMIT the first match is encoded, the addressed entry is
//   selected, the chain shifts and the result register loads, once that
//   register is free. A request is taken only in IDLE, after the last one has
//   committed; a new request is taken while a finished result still waits.
// Reset
//   Synchronous, active low. The list length returns to zero; cell contents
//   are left as they are and are never read before being written.
// Stall
//   While the result register is full and the receiver stalls, hold the next
//   request in its commit step and accept nothing further.
module positional_ordered_list #(
    parameter int CAPACITY = pol_pkg::DEF_CAPACITY
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [pol_pkg::OP_W-1:0]             i_op,
    input  logic [pol_pkg::POS_W-1:0]            i_position,
    input  logic signed [pol_pkg::DATA_W-1:0]    i_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [pol_pkg::STATUS_W-1:0]         o_status,
    output logic signed [pol_pkg::DATA_W-1:0]    o_data_out,
    output logic [pol_pkg::POS_W-1:0]            o_found_position,
    output logic [pol_pkg::POS_W-1:0]            o_list_length,
    output logic                                 o_is_empty
);
    import pol_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EVAL   = 3'b010,
        S_COMMIT = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [OP_W-1:0]     r_op;
    logic [POS_W-1:0]    r_pos;
    logic [DATA_W-1:0]   r_value;
    logic [CNT_W-1:0]    r_count, n_count;

    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [DATA_W-1:0]   r_data, n_data;
    logic [POS_W-1:0]    r_found, n_found;
    logic [POS_W-1:0]    r_len, n_len;

    logic in_accept;
    logic commit;

    t_cell_cmd cmd;

    logic [CAPACITY-1:0]             match;
    logic [CAPACITY-1:0][DATA_W-1:0] cell_val;
    logic [CAPACITY-1:0][DATA_W-1:0] cell_sel;
    logic [POS_W-1:0]                enc_found;
    logic [DATA_W-1:0]               enc_data;

    // Position checks run 11 bits wide so that length + 1 never wraps.
    logic [POS_W:0] pos_x;
    logic [POS_W:0] cnt_x;
    logic           pos_rd_ok;
    logic           pos_ins_ok;
    logic           list_full;
    logic           do_ins;
    logic           do_del;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    // Advance out of commit only when the result register is free.
    assign commit     = (r_state == S_COMMIT) && (!r_out_valid || i_out_ready);

    assign pos_x      = {1'b0, r_pos};
    assign cnt_x      = (POS_W + 1)'(r_count);
    assign pos_rd_ok  = (r_pos != '0) && (pos_x <= cnt_x);
    assign pos_ins_ok = (r_pos != '0) && (pos_x <= cnt_x + 1'b1);
    assign list_full  = (cnt_x >= (POS_W + 1)'(CAPACITY));
    assign do_ins     = (r_op == OP_INSERT) && pos_ins_ok && !list_full;
    assign do_del     = (r_op == OP_DELETE) && pos_rd_ok;

    always_comb begin
        cmd.eval  = (r_state == S_EVAL);
        cmd.ins   = commit && do_ins;
        cmd.del   = commit && do_del;
        cmd.idx   = r_pos - 1'b1;
        cmd.count = POS_W'(r_count);
        cmd.value = r_value;
    end

    // Chain of cells: each one hands its entry to both neighbours.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] left_val;
        logic [DATA_W-1:0] right_val;
        if (g == 0) begin : g_first
            assign left_val = cell_val[g];
        end else begin : g_mid_l
            assign left_val = cell_val[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_val = cell_val[g];
        end else begin : g_mid_r
            assign right_val = cell_val[g+1];
        end
        pol_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_left  (left_val),
            .i_right (right_val),
            .o_value (cell_val[g]),
            .o_match (match[g]),
            .o_sel   (cell_sel[g])
        );
    end

    pol_reduce #(
        .CAPACITY (CAPACITY)
    ) u_reduce (
        .i_match (match),
        .i_sel   (cell_sel),
        .o_found (enc_found),
        .o_data  (enc_data)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result and length update for the request in commit.
    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        n_data   = '0;
        n_found  = '0;
        case (r_op)
            OP_INSERT: begin
                if (!pos_ins_ok) begin
                    n_status = ST_BADPOS;
                end else if (list_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            OP_DELETE: begin
                if (!pos_rd_ok) begin
                    n_status = ST_BADPOS;
                end else begin
                    n_data  = enc_data;
                    n_count = r_count - 1'b1;
                end
            end
            OP_GET: begin
                if (!pos_rd_ok) begin
                    n_status = ST_BADPOS;
                end else begin
                    n_data = enc_data;
                end
            end
            OP_LOCATE: begin
                n_found  = enc_found;
                n_status = (enc_found == '0) ? ST_NOTFOUND : ST_OK;
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                // unused codes: leave the list alone
            end
        endcase
        n_len = POS_W'(n_count);
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (commit) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op    <= i_op;
            r_pos   <= i_position;
            r_value <= i_value;
        end
        if (commit) begin
            r_status <= n_status;
            r_data   <= n_data;
            r_found  <= n_found;
            r_len    <= n_len;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_data_out       = r_data;
    assign o_found_position = r_found;
    assign o_list_length    = r_len;
    assign o_is_empty       = (r_len == '0);

    // Length never passes the number of cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (POS_W + 1)'(r_count) <= (POS_W + 1)'(CAPACITY))
        else $error("list length above capacity");

    // An accepted request always goes to the compare step next.
    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_EVAL))
        else $error("accepted request did not enter compare step");

    // A commit always leaves a valid result behind it.
    a_commit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> (o_out_valid && (o_list_length == POS_W'(r_count))))
        else $error("commit did not load a matching result");

    // The length only moves at a commit.
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !commit |=> $stable(r_count))
        else $error("list length changed outside commit");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the positional ordered list: predictor, scoreboard and drivers.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pol_pkg::*;

    localparam int LIST_CAP = DEF_CAPACITY;

    // Op codes five to seven are spare; the block must ignore them.
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] VAL_MAX = ~VAL_MIN;

    // Leaning of one random phase: grow the list, shrink it, or mix.
    localparam int BIAS_GROW   = 0;
    localparam int BIAS_SHRINK = 1;
    localparam int BIAS_MIXED  = 2;

    localparam int RANDOM_REQUESTS = 1750;
    localparam int TAIL_CYCLES     = 8;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] data;
        logic [POS_W-1:0]         found;
        logic [POS_W-1:0]         length;
        logic                     empty;
    } t_list_result;

    // Mirror of the list contents plus the queue of results still owed by the block.
    class list_tracker;
        logic signed [DATA_W-1:0] cells [LIST_CAP];
        int count;
        t_list_result awaited[$];
        int errors;
        int requests;
        int results;
        int peak;
        int status_seen [4];

        function new();
            count    = 0;
            errors   = 0;
            requests = 0;
            results  = 0;
            peak     = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function int length();
            return count;
        endfunction

        function logic signed [DATA_W-1:0] entry_at(int idx);
            return cells[idx];
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] list check failed: %s", $time, msg);
        endtask

        // Apply one accepted request to the mirror and queue the result it owes.
        function void note_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                   logic signed [DATA_W-1:0] val);
            t_list_result r;
            int p;
            int k;
            p        = pos;
            r.status = ST_OK;
            r.data   = '0;
            r.found  = '0;
            case (op)
                OP_INSERT: begin
                    if (p < 1 || p > count + 1) begin
                        r.status = ST_BADPOS;
                    end else if (count >= LIST_CAP) begin
                        r.status = ST_FULL;
                    end else begin
                        for (k = count; k >= p; k--) cells[k] = cells[k-1];
                        cells[p-1] = val;
                        count++;
                    end
                end
                OP_DELETE: begin
                    if (p < 1 || p > count) begin
                        r.status = ST_BADPOS;
                    end else begin
                        r.data = cells[p-1];
                        for (k = p; k < count; k++) cells[k-1] = cells[k];
                        count--;
                    end
                end
                OP_GET: begin
                    if (p < 1 || p > count) r.status = ST_BADPOS;
                    else r.data = cells[p-1];
                end
                OP_LOCATE: begin
                    r.status = ST_NOTFOUND;
                    for (k = 0; k < count; k++) begin
                        if (cells[k] == val) begin
                            r.found  = POS_W'(k + 1);
                            r.status = ST_OK;
                            break;
                        end
                    end
                end
                OP_CLEAR: count = 0;
                default: ;
            endcase
            r.length = POS_W'(count);
            r.empty  = (count == 0);
            if (count > peak) peak = count;
            requests++;
            awaited.push_back(r);
        endfunction

        task check_result(t_list_result got);
            t_list_result want;
            if (awaited.size() == 0) begin
                report($sformatf("result with no request outstanding (status %0d)",
                                 got.status));
            end else begin
                want = awaited.pop_front();
                results++;
                status_seen[want.status]++;
                if (got.status !== want.status)
                    report($sformatf("status got %0d want %0d", got.status, want.status));
                if (got.data !== want.data)
                    report($sformatf("data_out got %0d want %0d", got.data, want.data));
                if (got.found !== want.found)
                    report($sformatf("found_position got %0d want %0d", got.found, want.found));
                if (got.length !== want.length)
                    report($sformatf("list_length got %0d want %0d", got.length, want.length));
                if (got.empty !== want.empty)
                    report($sformatf("is_empty got %0d want %0d", got.empty, want.empty));
            end
        endtask
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic [OP_W-1:0]          i_op;
    logic [POS_W-1:0]         i_position;
    logic signed [DATA_W-1:0] i_value;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic [STATUS_W-1:0]      o_status;
    logic signed [DATA_W-1:0] o_data_out;
    logic [POS_W-1:0]         o_found_position;
    logic [POS_W-1:0]         o_list_length;
    logic                     o_is_empty;

    list_tracker sb;
    bit          idle_en;
    int          sent;

    positional_ordered_list dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_op             (i_op),
        .i_position       (i_position),
        .i_value          (i_value),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_data_out       (o_data_out),
        .o_found_position (o_found_position),
        .o_list_length    (o_list_length),
        .o_is_empty       (o_is_empty)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop: far beyond the slowest legal run, stalls included.
    initial begin
        #5_000_000;
        $display("positional_ordered_list: mismatch");
        $finish;
    end

    // Result side: check every accepted result, then pick the next ready level.
    // Sampling happens in the active region of the edge, before any register update.
    always @(posedge i_clk) begin
        t_list_result got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.status = o_status;
            got.data   = o_data_out;
            got.found  = o_found_position;
            got.length = o_list_length;
            got.empty  = o_is_empty;
            sb.check_result(got);
        end
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !idle_en || ($urandom_range(99) >= 16);
        end
    end

    // Present one request, hold it until taken, then note it with the scoreboard.
    // Random idle cycles go in front; valid is never dropped while a request waits.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic signed [DATA_W-1:0] val);
        while (idle_en && $urandom_range(99) < 16) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_position <= pos;
        i_value    <= val;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(op, pos, val);
        sent++;
    endtask

    // Hold off the sender until the block owes nothing.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Favour a handful of recurring values so that locate hits and duplicates are common.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return -1;
            3:       return 0;
            4:       return DATA_W'($urandom_range(3));
            default: return $urandom;
        endcase
    endfunction

    // Build one random request, mostly well formed for the current list length.
    function automatic void pick_request(input int bias, output logic [OP_W-1:0] op,
                                         output logic [POS_W-1:0] pos,
                                         output logic signed [DATA_W-1:0] val);
        int r;
        int len;
        int cut_ins;
        int cut_del;
        int cut_get;
        int cut_loc;
        int cut_clr;
        len = sb.length();
        r   = $urandom_range(99);
        case (bias)
            BIAS_GROW: begin
                cut_ins = 70; cut_del = 78; cut_get = 88; cut_loc = 97; cut_clr = 98;
            end
            BIAS_SHRINK: begin
                cut_ins = 15; cut_del = 60; cut_get = 75; cut_loc = 90; cut_clr = 93;
            end
            default: begin
                cut_ins = 35; cut_del = 55; cut_get = 75; cut_loc = 93; cut_clr = 96;
            end
        endcase
        if (r < cut_ins)      op = OP_INSERT;
        else if (r < cut_del) op = OP_DELETE;
        else if (r < cut_get) op = OP_GET;
        else if (r < cut_loc) op = OP_LOCATE;
        else if (r < cut_clr) op = OP_CLEAR;
        else                  op = OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));

        pos = POS_W'($urandom_range(1023));
        val = pick_value();
        case (op)
            OP_INSERT: begin
                if ($urandom_range(99) < 85) begin
                    pos = POS_W'($urandom_range(len + 1, 1));
                end else begin
                    case ($urandom_range(2))
                        0:       pos = '0;
                        1:       pos = POS_W'(len + 2);
                        default: pos = POS_W'($urandom_range(1023, len + 2));
                    endcase
                end
            end
            OP_DELETE, OP_GET: begin
                if (len > 0 && $urandom_range(99) < 85) begin
                    pos = POS_W'($urandom_range(len, 1));
                end else begin
                    case ($urandom_range(2))
                        0:       pos = '0;
                        1:       pos = POS_W'(len + 1);
                        default: pos = POS_W'($urandom_range(1023, len + 1));
                    endcase
                end
            end
            OP_LOCATE: begin
                // Search for a stored value about half the time.
                if (len > 0 && $urandom_range(1) == 0)
                    val = sb.entry_at($urandom_range(len - 1));
            end
            default: ;
        endcase
    endfunction

    initial begin
        logic [OP_W-1:0]          op;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        int phase_len;
        int bias;
        int n;

        sb      = new();
        idle_en = 1'b1;
        sent    = 0;

        // Drive every input to a known level and hold reset asserted before releasing it.
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_op        <= OP_INSERT;
        i_position  <= '0;
        i_value     <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests: empty list, bad positions at both ends, extreme values,
        // first match among duplicates, spare op codes, clear of an empty and a non-empty list.
        send_request(OP_GET,    10'd1,    0);
        send_request(OP_DELETE, 10'd1,    0);
        send_request(OP_LOCATE, 10'd0,    0);
        send_request(OP_CLEAR,  10'd0,    0);
        send_request(OP_INSERT, 10'd0,    5);
        send_request(OP_INSERT, 10'd2,    5);
        send_request(OP_INSERT, 10'd1,    VAL_MIN);
        send_request(OP_INSERT, 10'd2,    VAL_MAX);
        send_request(OP_INSERT, 10'd1,    -1);
        send_request(OP_INSERT, 10'd4,    0);
        send_request(OP_INSERT, 10'd2,    VAL_MAX);
        send_request(OP_LOCATE, 10'd0,    VAL_MAX);
        send_request(OP_LOCATE, 10'd1023, 12345);
        send_request(OP_GET,    10'd1023, 0);
        send_request(OP_GET,    10'd5,    0);
        send_request(OP_GET,    10'd6,    0);
        send_request(OP_DELETE, 10'd0,    0);
        send_request(OP_DELETE, 10'd1023, 0);
        send_request(OP_DELETE, 10'd1,    0);
        send_request(OP_DELETE, 10'd4,    0);
        send_request(OP_INSERT, 10'd1023, -1);
        send_request(OP_SPARE_FIRST,      10'd1023, -1);
        send_request(OP_SPARE_FIRST + 3'd1, 10'd512,  VAL_MIN);
        send_request(OP_SPARE_LAST,       10'd1,    VAL_MAX);
        send_request(OP_CLEAR,  10'd1023, -1);

        // Pause the sender until the block has answered everything.
        drain_results();

        // Random phases; the middle stretch runs with no idling on either side.
        n = 0;
        while (n < RANDOM_REQUESTS) begin
            phase_len = $urandom_range(200, 60);
            if (phase_len > RANDOM_REQUESTS - n) phase_len = RANDOM_REQUESTS - n;
            case ($urandom_range(4))
                0, 1:    bias = BIAS_GROW;
                2:       bias = BIAS_SHRINK;
                default: bias = BIAS_MIXED;
            endcase
            idle_en = !(n >= 600 && n < 1000);
            repeat (phase_len) begin
                pick_request(bias, op, pos, val);
                send_request(op, pos, val);
                n++;
            end
            if ($urandom_range(2) == 0) drain_results();
        end

        // Wait for the last results, then idle for TAIL_CYCLES so that stray outputs can show.
        idle_en = 1'b1;
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d requests and %0d checked results, peak length %0d of %0d",
                 sent, sb.results, sb.peak, LIST_CAP);
        $display("statuses seen: ok %0d, bad position %0d, full %0d, not found %0d",
                 sb.status_seen[ST_OK], sb.status_seen[ST_BADPOS],
                 sb.status_seen[ST_FULL], sb.status_seen[ST_NOTFOUND]);
        if (sb.errors == 0) begin
            $display("positional_ordered_list: match");
        end else begin
            $display("positional_ordered_list: mismatch");
        end
        $finish;
    end

endmodule
